FILE: rtl/core/art_pkg.sv
// shared types, codes and widths of the allocation region tracker
package art_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  localparam int ADDR_W  = 64;
  localparam int SIZE_W  = 32;
  localparam int CNT_W   = 32;
  localparam int TOT_W   = 64;
  localparam int USED_W  = 8;
  localparam int ENTRY_W = ADDR_W + SIZE_W + 1;
  localparam int IN_W    = ADDR_W + SIZE_W;
  localparam int OUT_W   = 240;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_COMPACT = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DISABLED  = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [TOT_W-1:0]    current;
    logic [TOT_W-1:0]    peak;
    logic [CNT_W-1:0]    allocs;
    logic [CNT_W-1:0]    frees;
    logic [USED_W-1:0]   entries;
  } result_t;

endpackage

FILE: rtl/core/allocation_region_tracker_unit.sv
// Allocation region tracker: a table of up to TABLE_DEPTH regions held in one
// synchronous RAM (address, size, live bit per entry). Alloc appends an entry
// and goes straight to its result, as does an unused operation code. Free
// walks the table from entry 0 and stops at the first live entry whose address
// matches, or at the last used entry when none matches; compact always walks
// all used entries. The walk reads one entry per cycle from the RAM read port,
// so the table size sets the worst case. The table needs no clearing after
// reset; only entries below the fill count are ever checked. One item is
// worked on at a time; a finished result sits in an output register so the
// next beat is taken while it waits. tracking_enabled resets to 1; the user
// must write it through the cfg port only while the block is idle (unenforced).
module allocation_region_tracker_unit #(
  parameter int TABLE_DEPTH = art_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_data,       // tracking_enabled
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [art_pkg::IN_W-1:0]   in_tdata,       // region_addr, region_size
  input  logic [1:0]                 in_tuser,       // operation
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // status, current_bytes, peak_bytes, allocs_done, frees_done, live_regions,
  // entries_used, zero pad
  output logic [art_pkg::OUT_W-1:0]  out_tdata
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic                         track_en_r;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [art_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [art_pkg::ENTRY_W-1:0]  ram_rdata;
  logic                         res_valid;
  logic                         res_ready;
  art_pkg::result_t             res;
  logic                         out_valid_r;
  logic [art_pkg::OUT_W-1:0]    out_data_r;
  logic [art_pkg::CNT_W-1:0]    live_regions;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_en_r <= 1'b1;
    end else if (cfg_valid) begin
      track_en_r <= cfg_data;
    end
  end

  art_ram #(
    .WIDTH (art_pkg::ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  art_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .track_en  (track_en_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_op     (in_tuser),
    .in_addr   (in_tdata[art_pkg::ADDR_W-1:0]),
    .in_size   (in_tdata[art_pkg::ADDR_W +: art_pkg::SIZE_W]),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign live_regions = res.allocs - res.frees;
  assign res_ready    = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      out_data_r <= {6'b0, res.entries, live_regions, res.frees, res.allocs,
                     res.peak, res.current, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // an accepted beat always leaves the idle state
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // a full-table refusal reports the table at its depth
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.status == art_pkg::ST_FULL |->
      res.entries == art_pkg::USED_W'(TABLE_DEPTH))
    else $error("full status with table not full");

  // a handed-over result shows up on the output next cycle
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res_ready |=> out_tvalid)
    else $error("result lost on the way to the output");

endmodule

FILE: rtl/core/art_ram.sv
// generic simple dual-port ram with registered read
module art_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/art_engine.sv
// operation sequencer: totals, counters and table walks for free and compact
module art_engine #(
  parameter int TABLE_DEPTH = art_pkg::TABLE_DEPTH_DEF,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             track_en,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_op,
  input  logic [art_pkg::ADDR_W-1:0]       in_addr,
  input  logic [art_pkg::SIZE_W-1:0]       in_size,
  output logic                             ram_we,
  output logic [AW-1:0]                    ram_waddr,
  output logic [art_pkg::ENTRY_W-1:0]      ram_wdata,
  output logic [AW-1:0]                    ram_raddr,
  input  logic [art_pkg::ENTRY_W-1:0]      ram_rdata,
  output logic                             res_valid,
  input  logic                             res_ready,
  output art_pkg::result_t                 res
);

  typedef enum logic [1:0] {S_IDLE, S_FREE, S_CMP, S_RES} state_t;

  state_t                       state_r, state_nxt;
  logic [art_pkg::ADDR_W-1:0]   addr_r, addr_nxt;
  logic [AW-1:0]                chk_r, chk_nxt;
  logic [CW-1:0]                j_r, j_nxt;
  logic [CW-1:0]                used_r, used_nxt;
  logic [art_pkg::TOT_W-1:0]    total_r, total_nxt;
  logic [art_pkg::TOT_W-1:0]    peak_r, peak_nxt;
  logic [art_pkg::CNT_W-1:0]    allocs_r, allocs_nxt;
  logic [art_pkg::CNT_W-1:0]    frees_r, frees_nxt;
  art_pkg::status_t             status_r, status_nxt;

  logic                         rd_live;
  logic [art_pkg::SIZE_W-1:0]   rd_size;
  logic [art_pkg::ADDR_W-1:0]   rd_addr;
  logic [AW-1:0]                chk_inc;
  logic                         last;

  assign rd_live = ram_rdata[art_pkg::ENTRY_W-1];
  assign rd_size = ram_rdata[art_pkg::ADDR_W +: art_pkg::SIZE_W];
  assign rd_addr = ram_rdata[art_pkg::ADDR_W-1:0];
  assign chk_inc = chk_r + AW'(1);
  assign last    = (CW'(chk_r) + CW'(1)) == used_r;

  assign in_ready  = (state_r == S_IDLE);
  assign res_valid = (state_r == S_RES);
  // the next entry is fetched while the current one is checked
  assign ram_raddr = (state_r == S_IDLE) ? '0 : chk_inc;

  assign res.status  = status_r;
  assign res.current = total_r;
  assign res.peak    = peak_r;
  assign res.allocs  = allocs_r;
  assign res.frees   = frees_r;
  assign res.entries = art_pkg::USED_W'(used_r);

  always_comb begin
    logic [art_pkg::TOT_W-1:0] sum;
    logic [CW-1:0]             j_cnt;
    state_nxt  = state_r;
    addr_nxt   = addr_r;
    chk_nxt    = chk_r;
    j_nxt      = j_r;
    used_nxt   = used_r;
    total_nxt  = total_r;
    peak_nxt   = peak_r;
    allocs_nxt = allocs_r;
    frees_nxt  = frees_r;
    status_nxt = status_r;
    ram_we     = 1'b0;
    ram_waddr  = AW'(used_r);
    ram_wdata  = {1'b1, in_size, in_addr};
    sum        = total_r + {{(art_pkg::TOT_W-art_pkg::SIZE_W){1'b0}}, in_size};
    j_cnt      = j_r + (rd_live ? CW'(1) : CW'(0));
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          addr_nxt   = in_addr;
          chk_nxt    = '0;
          j_nxt      = '0;
          status_nxt = art_pkg::ST_OK;
          state_nxt  = S_RES;
          unique case (in_op)
            art_pkg::OP_ALLOC: begin
              if (!track_en) begin
                status_nxt = art_pkg::ST_DISABLED;
              end else if (used_r >= CW'(TABLE_DEPTH)) begin
                status_nxt = art_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                used_nxt   = used_r + CW'(1);
                total_nxt  = sum;
                allocs_nxt = allocs_r + art_pkg::CNT_W'(1);
                if (sum > peak_r) begin
                  peak_nxt = sum;
                end
              end
            end
            art_pkg::OP_FREE: begin
              if (used_r == '0) begin
                status_nxt = art_pkg::ST_NOT_FOUND;
              end else begin
                state_nxt = S_FREE;
              end
            end
            art_pkg::OP_COMPACT: begin
              if (used_r != '0) begin
                state_nxt = S_CMP;
              end
            end
            default: ;
          endcase
        end
      end
      S_FREE: begin
        if (rd_live && rd_addr == addr_r) begin
          ram_we     = 1'b1;
          ram_waddr  = chk_r;
          ram_wdata  = {1'b0, rd_size, rd_addr};
          total_nxt  = total_r - {{(art_pkg::TOT_W-art_pkg::SIZE_W){1'b0}}, rd_size};
          frees_nxt  = frees_r + art_pkg::CNT_W'(1);
          state_nxt  = S_RES;
        end else if (last) begin
          status_nxt = art_pkg::ST_NOT_FOUND;
          state_nxt  = S_RES;
        end else begin
          chk_nxt = chk_inc;
        end
      end
      S_CMP: begin
        // live entries slide down to the write pointer; it never passes the read side
        if (rd_live && CW'(chk_r) != j_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(j_r);
          ram_wdata = ram_rdata;
        end
        j_nxt = j_cnt;
        if (last) begin
          used_nxt  = j_cnt;
          state_nxt = S_RES;
        end else begin
          chk_nxt = chk_inc;
        end
      end
      S_RES: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      used_r   <= '0;
      total_r  <= '0;
      peak_r   <= '0;
      allocs_r <= '0;
      frees_r  <= '0;
      status_r <= art_pkg::ST_OK;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      total_r  <= total_nxt;
      peak_r   <= peak_nxt;
      allocs_r <= allocs_nxt;
      frees_r  <= frees_nxt;
      status_r <= status_nxt;
    end
    addr_r <= addr_nxt;
    chk_r  <= chk_nxt;
    j_r    <= j_nxt;
  end

endmodule
